/* rtl/core/cts_pkg.sv */
// Package for the cosine series core: fixed-point sizes, register indexes,
// reset values and the reciprocal table of (2n+1)(2n+2).
// Depends on nothing; used by every module in rtl/core.
package cts_pkg;

  localparam int FRAC_BITS     = 30;
  localparam int MAX_TERMS_DEF = 12;
  localparam int TABLE_DEPTH   = 16;

  localparam int MAG_W  = FRAC_BITS + 1;
  localparam int PROD_W = 2 * MAG_W;
  localparam int SUM_W  = FRAC_BITS + 3;

  localparam logic [63:0] ONE = 64'd1 << FRAC_BITS;

  localparam int X_W      = 31;
  localparam int SUM_OUT_W = 32;
  localparam int COUNT_W  = 4;
  localparam int EPS_W    = 31;
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 32;

  localparam logic [1:0] REG_TERM_COUNT = 2'd0;
  localparam logic [1:0] REG_STOP_MODE  = 2'd1;
  localparam logic [1:0] REG_EPS        = 2'd2;

  localparam logic [COUNT_W-1:0] TERM_COUNT_RST = 4'd7;
  localparam logic               STOP_MODE_RST  = 1'b0;
  localparam logic [EPS_W-1:0]   EPS_RST        = 31'd107374;

  typedef logic [FRAC_BITS-1:0] recip_t;
  typedef logic [MAG_W-1:0]     mag_t;
  typedef logic [PROD_W-1:0]    prod_t;

  localparam recip_t RECIP_TABLE [TABLE_DEPTH] = '{
    FRAC_BITS'(ONE / 64'd2),   FRAC_BITS'(ONE / 64'd12),  FRAC_BITS'(ONE / 64'd30),
    FRAC_BITS'(ONE / 64'd56),  FRAC_BITS'(ONE / 64'd90),  FRAC_BITS'(ONE / 64'd132),
    FRAC_BITS'(ONE / 64'd182), FRAC_BITS'(ONE / 64'd240), FRAC_BITS'(ONE / 64'd306),
    FRAC_BITS'(ONE / 64'd380), FRAC_BITS'(ONE / 64'd462), FRAC_BITS'(ONE / 64'd552),
    FRAC_BITS'(ONE / 64'd650), FRAC_BITS'(ONE / 64'd756), FRAC_BITS'(ONE / 64'd870),
    FRAC_BITS'(ONE / 64'd992)
  };

endpackage

/* rtl/core/cts_mul.sv */
// Shared multiplier of the cosine series core, with a registered product.
// Depends on cts_pkg for the operand and product types.
module cts_mul (
  input  logic          clk,
  input  cts_pkg::mag_t op_a,
  input  cts_pkg::mag_t op_b,
  output cts_pkg::prod_t product
);
  import cts_pkg::*;

  always_ff @(posedge clk) begin
    product <= op_a * op_b;
  end

endmodule

/* rtl/core/cosine_taylor_series_core.sv */
// Cosine by its Maclaurin series: one argument in, one word out.
// Each term added costs two passes through the one shared multiplier and a sum update;
// the other steps square the argument, check the first term and load the output.
// A new word is taken only once the sequencer is back in idle.
// Synchronous reset clears the sequencer and the output valid and loads term_count 7,
// stop_mode 0, epsilon 107374.
module cosine_taylor_series_core #(
  parameter int MAX_TERMS = cts_pkg::MAX_TERMS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cts_pkg::PADDR_W-1:0]   paddr,
  input  logic [cts_pkg::PDATA_W-1:0]   pwdata,
  output logic [cts_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [cts_pkg::X_W-1:0]       x_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [cts_pkg::SUM_OUT_W-1:0] cos_sum,
  output logic [cts_pkg::COUNT_W-1:0]   terms_used,
  output logic                          hit_limit
);
  import cts_pkg::*;

  localparam int CNT_W = $clog2(MAX_TERMS + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_TERMS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SQ   = 3'd1;
  localparam logic [2:0] S_X2   = 3'd2;
  localparam logic [2:0] S_CHK  = 3'd3;
  localparam logic [2:0] S_M2   = 3'd4;
  localparam logic [2:0] S_UPD  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [COUNT_W-1:0] term_count;
  logic               stop_mode;
  logic [EPS_W-1:0]   eps_threshold;

  logic [2:0]              state;
  mag_t                    x_reg;
  mag_t                    x2;
  mag_t                    mag;
  logic signed [SUM_W-1:0] sum;
  logic                    negative;
  logic [CNT_W-1:0]        n;

  mag_t  op_a;
  mag_t  op_b;
  prod_t product;
  mag_t  prod_hi;

  logic               cfg_write;
  logic [CNT_W-1:0]   steps;
  logic               mag_above_eps;
  logic               stop;
  logic [63:0]        x_ext;
  logic signed [63:0] sum_ext;
  logic signed [SUM_OUT_W-1:0] sum_sat;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;
  assign in_stall  = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      term_count    <= TERM_COUNT_RST;
      stop_mode     <= STOP_MODE_RST;
      eps_threshold <= EPS_RST;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        REG_TERM_COUNT: term_count    <= pwdata[COUNT_W-1:0];
        REG_STOP_MODE:  stop_mode     <= pwdata[0];
        REG_EPS:        eps_threshold <= pwdata[EPS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_TERM_COUNT: prdata = PDATA_W'(term_count);
      REG_STOP_MODE:  prdata = PDATA_W'(stop_mode);
      REG_EPS:        prdata = PDATA_W'(eps_threshold);
      default:        prdata = '0;
    endcase
  end

  always_comb begin
    if (stop_mode) begin
      steps = MAX_CNT;
    end else if (32'(term_count) > 32'(MAX_TERMS)) begin
      steps = MAX_CNT;
    end else begin
      steps = CNT_W'(term_count);
    end
  end

  assign prod_hi       = product[2*FRAC_BITS:FRAC_BITS];
  assign mag_above_eps = 64'(mag) > 64'(eps_threshold);
  assign stop          = (n == steps) || (stop_mode && !mag_above_eps);
  assign x_ext         = (64'(x_value) > ONE) ? ONE : 64'(x_value);
  assign sum_ext       = 64'(sum);

  always_comb begin
    if (sum_ext > 64'sd2147483647) begin
      sum_sat = SUM_OUT_W'(64'sd2147483647);
    end else if (sum_ext < -64'sd2147483648) begin
      sum_sat = SUM_OUT_W'(-64'sd2147483648);
    end else begin
      sum_sat = SUM_OUT_W'(sum_ext);
    end
  end

  always_comb begin
    unique case (state)
      S_SQ: begin
        op_a = x_reg;
        op_b = x_reg;
      end
      S_CHK: begin
        op_a = mag;
        op_b = x2;
      end
      S_M2: begin
        op_a = prod_hi;
        op_b = MAG_W'(RECIP_TABLE[COUNT_W'(n)]);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  cts_mul u_mul (
    .clk     (clk),
    .op_a    (op_a),
    .op_b    (op_b),
    .product (product)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == S_DONE && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            x_reg    <= MAG_W'(x_ext);
            mag      <= MAG_W'(ONE);
            sum      <= SUM_W'(ONE);
            negative <= 1'b0;
            n        <= '0;
            state    <= S_SQ;
          end
        end
        S_SQ: begin
          state <= S_X2;
        end
        S_X2: begin
          x2    <= prod_hi;
          state <= S_CHK;
        end
        S_CHK: begin
          state <= stop ? S_DONE : S_M2;
        end
        S_M2: begin
          state <= S_UPD;
        end
        S_UPD: begin
          mag      <= prod_hi;
          negative <= !negative;
          if (!negative) begin
            sum <= sum - $signed(SUM_W'(prod_hi));
          end else begin
            sum <= sum + $signed(SUM_W'(prod_hi));
          end
          n     <= n + 1'b1;
          state <= S_CHK;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            cos_sum    <= sum_sat;
            terms_used <= COUNT_W'(n);
            hit_limit  <= stop_mode && (n == MAX_CNT) && mag_above_eps;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* bench/cts_checker.sv */
// Checker for the cosine series core: follows the register port and both word
// channels, predicts each result and compares it with the word that comes out.
// Depends on cts_pkg for sizes, register indexes and reset values.
module cos_series_checker #(
  parameter int MAX_TERMS = cts_pkg::MAX_TERMS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic                                 pready,
  input  logic [cts_pkg::PADDR_W-1:0]          paddr,
  input  logic [cts_pkg::PDATA_W-1:0]          pwdata,
  input  logic                                 in_valid,
  input  logic                                 in_stall,
  input  logic [cts_pkg::X_W-1:0]              x_value,
  input  logic                                 out_valid,
  input  logic                                 out_stall,
  input  logic signed [cts_pkg::SUM_OUT_W-1:0] cos_sum,
  input  logic [cts_pkg::COUNT_W-1:0]          terms_used,
  input  logic                                 hit_limit,
  output int                                   pending,
  output int                                   checked,
  output int                                   mismatches
);
  timeunit 1ns;
  timeprecision 1ps;
  import cts_pkg::*;

  typedef struct packed {
    logic signed [SUM_OUT_W-1:0] sum;
    logic [COUNT_W-1:0]          count;
    logic                        hit;
  } cos_word_t;

  logic [COUNT_W-1:0] term_count_q;
  logic               stop_mode_q;
  logic [EPS_W-1:0]   eps_q;
  cos_word_t          expected_words[$];

  function automatic logic [63:0] mul_frac(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[FRAC_BITS +: 64];
  endfunction

  function automatic cos_word_t cosine_series(logic [X_W-1:0] x_in);
    logic [63:0]        x, sq, mag, recip;
    logic signed [63:0] acc;
    logic               negative;
    int unsigned        steps, n;
    cos_word_t          r;
    x = 64'(x_in);
    if (x > ONE) begin
      x = ONE;
    end
    sq = mul_frac(x, x);
    mag = ONE;
    acc = $signed(ONE);
    negative = 1'b0;
    n = 0;
    if (stop_mode_q) begin
      steps = MAX_TERMS;
    end else begin
      steps = (term_count_q > MAX_TERMS) ? MAX_TERMS : term_count_q;
    end
    while (n < steps) begin
      if (stop_mode_q && mag <= eps_q) begin
        break;
      end
      recip = ONE / 64'((2 * n + 1) * (2 * n + 2));
      mag = mul_frac(mul_frac(mag, sq), recip);
      negative = !negative;
      acc = negative ? acc - $signed(mag) : acc + $signed(mag);
      n++;
    end
    r.hit = stop_mode_q && n == MAX_TERMS && mag > eps_q;
    if (acc > 64'sd2147483647) begin
      acc = 64'sd2147483647;
    end
    if (acc < -64'sd2147483648) begin
      acc = -64'sd2147483648;
    end
    r.sum = acc[SUM_OUT_W-1:0];
    r.count = n[COUNT_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    cos_word_t got, want;
    int        bad;
    bad = 0;
    if (rst) begin
      term_count_q = TERM_COUNT_RST;
      stop_mode_q = STOP_MODE_RST;
      eps_q = EPS_RST;
      expected_words.delete();
      pending <= 0;
      checked <= 0;
      mismatches <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_TERM_COUNT: term_count_q = pwdata[COUNT_W-1:0];
          REG_STOP_MODE:  stop_mode_q = pwdata[0];
          REG_EPS:        eps_q = pwdata[EPS_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got = {cos_sum, terms_used, hit_limit};
        if (expected_words.size() == 0) begin
          $error("result word with nothing expected: cos_sum %0d, terms_used %0d",
                 got.sum, got.count);
          bad++;
        end else begin
          want = expected_words.pop_front();
          if (got.sum !== want.sum) begin
            $error("cos_sum: expected %0d, got %0d", want.sum, got.sum);
            bad++;
          end
          if (got.count !== want.count) begin
            $error("terms_used: expected %0d, got %0d", want.count, got.count);
            bad++;
          end
          if (got.hit !== want.hit) begin
            $error("hit_limit: expected %0d, got %0d", want.hit, got.hit);
            bad++;
          end
        end
        checked <= checked + 1;
      end
      if (in_valid && !in_stall) begin
        expected_words.push_back(cosine_series(x_value));
      end
      pending <= expected_words.size();
      mismatches <= mismatches + bad;
    end
  end

endmodule

/* bench/tb_top.sv */
// Top of the cosine series bench: clock, reset, register writes, argument
// stimulus with random gaps and stalls, watchdog and verdict.
// Depends on cts_pkg, cosine_taylor_series_core and cos_series_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import cts_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 2000;
  localparam int PHASES = 10;
  localparam int PHASE_ARGS = 75;

  logic                        clk;
  logic                        rst = 1'b1;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [PADDR_W-1:0]          paddr = '0;
  logic [PDATA_W-1:0]          pwdata = '0;
  logic [PDATA_W-1:0]          prdata;
  logic                        pready;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [X_W-1:0]              x_value = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic signed [SUM_OUT_W-1:0] cos_sum;
  logic [COUNT_W-1:0]          terms_used;
  logic                        hit_limit;

  int pending, words_checked, mismatches;
  int send_idle_pct, recv_idle_pct;
  int args_sent, settings_used;
  int quiet_cycles;

  cosine_taylor_series_core dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .x_value(x_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .cos_sum(cos_sum), .terms_used(terms_used), .hit_limit(hit_limit)
  );

  cos_series_checker u_checker (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .in_valid(in_valid), .in_stall(in_stall), .x_value(x_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .cos_sum(cos_sum), .terms_used(terms_used), .hit_limit(hit_limit),
    .pending(pending), .checked(words_checked), .mismatches(mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // The receiver stalls at random, and once, midway, holds off long enough
  // for the core to fill up and stall its input.
  initial begin : receiver
    bit held;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && words_checked >= 400) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [PDATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [COUNT_W-1:0] count, input logic mode,
                           input logic [EPS_W-1:0] eps);
    write_reg(REG_TERM_COUNT, ($urandom & ~32'hF) | PDATA_W'(count));
    write_reg(REG_STOP_MODE, ($urandom & ~32'h1) | PDATA_W'(mode));
    write_reg(REG_EPS, {1'($urandom_range(1)), eps});
    settings_used++;
  endtask

  task automatic send_arg(input logic [X_W-1:0] arg);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    x_value <= arg;
    do @(posedge clk); while (in_stall);
    args_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [X_W-1:0] pick_arg();
    logic [X_W-1:0] corners[6];
    corners = '{'0, X_W'(1), X_W'(ONE) - 1, X_W'(ONE), X_W'(ONE) + 1, '1};
    case ($urandom_range(9))
      0:       return X_W'($urandom);
      1:       return corners[$urandom_range(5)];
      2:       return X_W'($urandom_range(32'h0001_0000));
      default: return X_W'($urandom_range(32'h4000_0000));
    endcase
  endfunction

  initial begin : stimulus
    logic [COUNT_W-1:0] count;
    logic [EPS_W-1:0]   eps;
    send_idle_pct = 13;
    recv_idle_pct = 65;
    args_sent = 0;
    settings_used = 1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: fixed mode with seven steps; extremes of the argument,
    // including values above one that the core saturates.
    send_arg('0);
    send_arg(X_W'(1));
    send_arg(X_W'(ONE) - 1);
    send_arg(X_W'(ONE));
    send_arg(X_W'(ONE) + 1);
    send_arg('1);
    send_arg(31'h5555_5555);
    send_arg(31'h2AAA_AAAA);
    send_arg(X_W'(ONE >> 1));
    drain();
    write_reg(REG_TERM_COUNT, '0);
    send_arg(X_W'(ONE));
    send_arg('0);
    drain();
    write_reg(REG_TERM_COUNT, 32'hF);
    send_arg(X_W'(ONE));
    drain();
    write_reg(REG_STOP_MODE, 32'h1);
    send_arg('0);
    send_arg(X_W'(ONE));
    send_arg(X_W'(ONE >> 1));
    drain();
    write_reg(REG_EPS, '0);
    send_arg(X_W'(ONE));
    send_arg('0);
    drain();
    write_reg(REG_UNUSED, '1);
    send_arg(X_W'(ONE));
    drain();
    settings_used += 4;

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph < 4) begin
        send_idle_pct = 13;
        recv_idle_pct = 65;
      end else if (ph < 7) begin
        send_idle_pct = 65;
        recv_idle_pct = 13;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (ph)
        0:       count = 4'd12;
        2:       count = 4'd1;
        4:       count = 4'd0;
        6:       count = 4'd15;
        default: count = COUNT_W'($urandom_range(15));
      endcase
      case (ph)
        1:       eps = '0;
        3:       eps = '1;
        7:       eps = EPS_W'(ONE);
        default: eps = EPS_W'($urandom_range(32'h0010_0000) >> $urandom_range(20));
      endcase
      configure(count, 1'(ph % 2), eps);
      repeat (PHASE_ARGS) send_arg(pick_arg());
      drain();
    end

    repeat (50) @(posedge clk);
    $display("Run covered %0d arguments over %0d register settings in fixed and epsilon mode,",
             args_sent, settings_used);
    $display("with %0d result words checked under sender gaps and receiver stalls.",
             words_checked);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/cts_pkg.sv
rtl/core/cts_mul.sv
rtl/core/cosine_taylor_series_core.sv
bench/cts_checker.sv
bench/tb_top.sv
